FILE: src/periodic_subscription_table_macros.svh
// Assertion macros shared by the subscription table RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef PERIODIC_SUBSCRIPTION_TABLE_MACROS_SVH
`define PERIODIC_SUBSCRIPTION_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pst check failed");

// Next-cycle implication, disabled during reset.
`define PST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pst check failed");

`endif

FILE: src/pst_pkg.sv
// Types and constants of the periodic subscription table.
// No dependencies; imported by pst_div and periodic_subscription_table.
`timescale 1ns / 1ps
`default_nettype none
package pst_pkg;

   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 32;

   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_CLAIM  = 3'd2;
   localparam logic [2:0] OP_FIND   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BADCOUNT = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NONE     = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FREE,
      S_DIV_ADD,
      S_ALLOC,
      S_SCAN,
      S_WRITE_ADD,
      S_DIV_CLAIM
   } state_type;

   typedef struct packed {
      logic [15:0] ident;
      logic [31:0] period;
      logic [63:0] due;
      logic [15:0] fields;
   } entry_type;

endpackage
`default_nettype wire

FILE: src/pst_div.sv
// Bit-serial restoring divider, remainder only: 64-bit dividend, 32-bit divisor.
// Depends on pst_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none
module pst_div
   import pst_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 go,
   input  wire logic [DIV_NUM_W-1:0] dividend,
   input  wire logic [DIV_DEN_W-1:0] divisor,
   output logic                      done,
   output logic [DIV_DEN_W-1:0]      remainder
);
   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W:0]   trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
         num_in = dividend;
         den_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

FILE: src/periodic_subscription_table.sv
// Top level of the periodic subscription table: control FSM, entry memory.
// Depends on pst_pkg, pst_div and periodic_subscription_table_macros.svh.
//
// Usage:
//   A request is taken when start is high and busy is low. The req_ ports
//   carry operation, period, field count, time and id. Exactly one result
//   follows, shown on the rsp_ ports for one cycle while rsp_valid is high;
//   the receiver cannot stall it. busy drops in the cycle the result shows,
//   so the next request can be taken then.
//   The csr_ channel writes scheduler_period (0 is stored as 1) whenever
//   csr_ready is high, i.e. while not busy.
//   Time from accept to result (N = NUM_SLOTS) is set by the one-read-port
//   entry memory scan and the one-bit-a-cycle remainder unit; the steps:
//     clear, bad count, full, unknown: answered from the idle state
//     find, remove, nothing due:       a scan of up to N slots
//     claim of a due entry:            a scan, plus the remainder
//     add: a free-slot search of up to N slots, the remainder when the period
//          exceeds the tick, a scan per id candidate (at most N + 1), then the write
//   Reset clears all slots, sets next id to 1 and the tick to 1; the memory
//   contents are not cleared, entries are read only once written.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_subscription_table_macros.svh"
module periodic_subscription_table
   import pst_pkg::*;
#(
   parameter int NUM_SLOTS   = 16,
   parameter int FIELD_LIMIT = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_operation,
   input  wire logic [31:0] req_requested_period,
   input  wire logic [15:0] req_field_count,
   input  wire logic [63:0] req_now_time,
   input  wire logic [15:0] req_sub_id,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_slot,
   output logic [15:0]      rsp_entry_id,
   output logic [31:0]      rsp_entry_period,
   output logic [63:0]      rsp_entry_next_due,
   output logic [15:0]      rsp_entry_fields,
   output logic [4:0]       rsp_live_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_wdata
);
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int TRY_W  = $clog2(NUM_SLOTS + 2);

   state_type             state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [31:0]           req_period_ff, req_period_in;
   logic [15:0]           fc_ff, fc_in;
   logic [63:0]           now_ff, now_in;
   logic [15:0]           id_ff, id_in;
   logic [31:0]           sp_ff;
   logic [NUM_SLOTS-1:0]  active_ff, active_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [15:0]           next_id_ff, next_id_in;
   logic [15:0]           cand_ff, cand_in;
   logic [TRY_W-1:0]      tries_ff, tries_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [31:0]           period_ff, period_in;
   entry_type             hit_ff, hit_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [3:0]            rsp_slot_ff, rsp_slot_in;
   entry_type             rsp_ent_ff, rsp_ent_in;
   logic [4:0]            rsp_count_ff, rsp_count_in;

   entry_type             mem [NUM_SLOTS];
   entry_type             mem_q_ff;
   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_wa;
   entry_type             mem_wd;
   logic [SLOT_W-1:0]     mem_ra;

   logic                  div_go;
   logic [63:0]           div_num;
   logic [31:0]           div_den;
   logic                  div_done;
   logic [31:0]           div_rem;

   logic                  scan_hit;
   logic [15:0]           scan_key;
   logic [15:0]           id_inc;
   logic [31:0]           adj;
   logic [32:0]           round_sum;
   logic [64:0]           due_sum;
   logic [63:0]           claim_base;
   logic [64:0]           claim_sum;

   pst_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[mem_ra];
   end

   assign scan_key = (op_ff == OP_ADD) ? cand_ff : id_ff;
   assign scan_hit = rd_vld_ff && active_ff[rd_idx_ff] &&
                     ((op_ff == OP_CLAIM) ? (now_ff >= mem_q_ff.due)
                                          : (mem_q_ff.ident == scan_key));
   assign id_inc     = next_id_ff + 16'd1;
   assign adj        = (div_rem == 32'd0) ? 32'd0 : (sp_ff - div_rem);
   assign round_sum  = {1'b0, req_period_ff} + {1'b0, adj};
   assign due_sum    = {1'b0, now_ff} + {33'd0, period_ff};
   assign claim_base = now_ff - {32'd0, div_rem};
   assign claim_sum  = {1'b0, claim_base} + {33'd0, hit_ff.period};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      req_period_in = req_period_ff;
      fc_in         = fc_ff;
      now_in        = now_ff;
      id_in         = id_ff;
      active_in     = active_ff;
      count_in      = count_ff;
      next_id_in    = next_id_ff;
      cand_in       = cand_ff;
      tries_in      = tries_ff;
      slot_in       = slot_ff;
      issue_in      = issue_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      period_in     = period_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_ent_in    = rsp_ent_ff;
      mem_we        = 1'b0;
      mem_wa        = slot_ff;
      mem_wd        = hit_ff;
      mem_ra        = issue_ff[SLOT_W-1:0];
      div_go        = 1'b0;
      div_num       = {32'd0, req_period_ff};
      div_den       = sp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in         = req_operation;
               req_period_in = req_requested_period;
               fc_in         = req_field_count;
               now_in        = req_now_time;
               id_in         = req_sub_id;
               issue_in      = '0;
               rsp_ent_in    = '0;
               rsp_slot_in   = '0;
               priority if (req_operation == OP_ADD) begin
                  if (req_field_count == 16'd0 ||
                      req_field_count > 16'(FIELD_LIMIT)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_BADCOUNT;
                  end else if (count_ff == CNT_W'(NUM_SLOTS)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FULL;
                  end else begin
                     state_in = S_FREE;
                  end
               end else if (req_operation == OP_REMOVE || req_operation == OP_FIND ||
                            req_operation == OP_CLAIM) begin
                  state_in = S_SCAN;
               end else if (req_operation == OP_CLEAR) begin
                  active_in     = '0;
                  count_in      = '0;
                  next_id_in    = 16'd1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NONE;
               end
            end
         end

         // a free slot exists: the count was below the table size
         S_FREE: begin
            tries_in = '0;
            if (!active_ff[issue_ff[SLOT_W-1:0]]) begin
               slot_in = issue_ff[SLOT_W-1:0];
               if (req_period_ff == 32'd0 || req_period_ff <= sp_ff) begin
                  period_in = sp_ff;
                  state_in  = S_ALLOC;
               end else begin
                  div_go   = 1'b1;
                  state_in = S_DIV_ADD;
               end
            end else begin
               issue_in = issue_ff + 1'b1;
            end
         end

         S_DIV_ADD: begin
            if (div_done) begin
               period_in = round_sum[32] ? 32'hFFFF_FFFF : round_sum[31:0];
               state_in  = S_ALLOC;
            end
         end

         S_ALLOC: begin
            cand_in    = next_id_ff;
            next_id_in = (id_inc == 16'd0) ? 16'd1 : id_inc;
            tries_in   = tries_ff + 1'b1;
            issue_in   = '0;
            state_in   = S_SCAN;
         end

         S_SCAN: begin
            if (issue_ff != CNT_W'(NUM_SLOTS)) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[SLOT_W-1:0];
               issue_in  = issue_ff + 1'b1;
            end
            if (scan_hit) begin
               rd_vld_in = 1'b0;
               unique case (op_ff)
                  OP_ADD: begin
                     // candidate id in use: try the next one, keep the free slot
                     if (tries_ff == TRY_W'(NUM_SLOTS + 1)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                        state_in      = S_IDLE;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  OP_CLAIM: begin
                     slot_in  = rd_idx_ff;
                     hit_in   = mem_q_ff;
                     div_go   = 1'b1;
                     div_num  = now_ff - mem_q_ff.due;
                     div_den  = mem_q_ff.period;
                     state_in = S_DIV_CLAIM;
                  end
                  OP_REMOVE: begin
                     active_in[rd_idx_ff] = 1'b0;
                     count_in      = count_ff - 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_slot_in   = 4'(rd_idx_ff);
                     rsp_ent_in    = mem_q_ff;
                     state_in      = S_IDLE;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_slot_in   = 4'(rd_idx_ff);
                     rsp_ent_in    = mem_q_ff;
                     state_in      = S_IDLE;
                  end
               endcase
            end else if (!rd_vld_ff && issue_ff == CNT_W'(NUM_SLOTS)) begin
               if (op_ff == OP_ADD) begin
                  state_in = S_WRITE_ADD;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NONE;
                  state_in      = S_IDLE;
               end
            end
         end

         S_WRITE_ADD: begin
            mem_wd.ident  = cand_ff;
            mem_wd.period = period_ff;
            mem_wd.due    = due_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : due_sum[63:0];
            mem_wd.fields = fc_ff;
            mem_we        = 1'b1;
            active_in[slot_ff] = 1'b1;
            count_in      = count_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_slot_in   = 4'(slot_ff);
            rsp_ent_in    = mem_wd;
            state_in      = S_IDLE;
         end

         S_DIV_CLAIM: begin
            if (div_done) begin
               mem_wd.due = claim_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : claim_sum[63:0];
               mem_we        = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_slot_in   = 4'(slot_ff);
               rsp_ent_in    = mem_wd;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_count_in = rsp_valid_in ? 5'(count_in) : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         count_ff     <= '0;
         next_id_ff   <= 16'd1;
         sp_ff        <= 32'd1;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            sp_ff <= (csr_wdata == 32'd0) ? 32'd1 : csr_wdata;
         end
      end
      op_ff         <= op_in;
      req_period_ff <= req_period_in;
      fc_ff         <= fc_in;
      now_ff        <= now_in;
      id_ff         <= id_in;
      cand_ff       <= cand_in;
      tries_ff      <= tries_in;
      slot_ff       <= slot_in;
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      period_ff     <= period_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_ent_ff    <= rsp_ent_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign csr_ready          = ~busy;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_entry_id       = rsp_ent_ff.ident;
   assign rsp_entry_period   = rsp_ent_ff.period;
   assign rsp_entry_next_due = rsp_ent_ff.due;
   assign rsp_entry_fields   = rsp_ent_ff.fields;
   assign rsp_live_count     = rsp_count_ff;

   `PST_ASSERT_NOW(a_count_matches, clock, reset, 1'b1,
                   count_ff == CNT_W'($countones(active_ff)))
   `PST_ASSERT_NOW(a_strobe_when_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE)
   `PST_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy,
                    busy || rsp_valid_ff)
   `PST_ASSERT_NOW(a_next_id_nonzero, clock, reset, 1'b1, next_id_ff != 16'd0)
   `PST_ASSERT_NOW(a_write_owner, clock, reset, mem_we,
                   state_ff == S_WRITE_ADD || state_ff == S_DIV_CLAIM)

endmodule
`default_nettype wire
